[rtl/bec_pkg.sv]
// Package: shared types and constants for the byte entropy classifier.
package bec_pkg;
	localparam int BINS = 256;
	localparam int BIN_W = 8;
	localparam int FRAC_BITS = 16;
	localparam logic [15:0] ENTROPY_MAX = 16'd32768;
	localparam logic [14:0] HIGH_RESET = 15'd28672;
	localparam logic [14:0] MEDIUM_RESET = 15'd20480;
	localparam logic REG_HIGH = 1'b0;
	localparam logic REG_MEDIUM = 1'b1;

	typedef enum logic [3:0] {
		ST_RUN,
		ST_SUM_RD,
		ST_SUM_LOG,
		ST_SUM_ACC,
		ST_WHOLE,
		ST_DIV,
		ST_CLASS,
		ST_CONF,
		ST_OUT
	} bec_state_t;

	typedef struct packed {
		logic clear_bins;
		logic start_log;
		logic acc_part;
		logic load_whole;
		logic start_div;
		logic finish_h;
		logic start_conf;
		logic finish_conf;
		logic next_bin;
	} bec_cmd_t;

	typedef struct packed {
		logic log_busy;
		logic div_busy;
		logic bin_wrap;
		logic count_zero;
		logic packed_flag;
	} bec_sts_t;
endpackage

[rtl/bec_ram.sv]
// Generic single-write, single-read RAM with registered read.
module bec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/bec_log2.sv]
// Iterative fixed-point log2 in Q.16, one fraction bit per cycle.
module bec_log2 import bec_pkg::*; #(
	parameter int XW = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [XW-1:0]        x,
	output logic                 busy,
	output logic [$clog2(XW)+15:0] result
);
	localparam int NW = $clog2(XW);

	logic [32:0] m_q;
	logic [15:0] frac_q;
	logic [NW-1:0] n_q;
	logic [4:0] cnt_q;
	logic [NW-1:0] msb;
	logic [31:0] norm;
	logic [65:0] sq;
	logic [34:0] msq;

	always_comb begin
		msb = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) begin
				msb = NW'(i);
			end
		end
		// x placed so its leading one lands on bit 31
		norm = 32'({x, 32'd0} >> (1 + int'(msb)));
	end

	assign sq = 66'(m_q) * 66'(m_q);
	assign msq = 35'(sq >> 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'(FRAC_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= {1'b0, norm};
			n_q <= msb;
			frac_q <= '0;
		end else if (cnt_q != '0) begin
			if (msq[34:32] != '0) begin
				frac_q <= {frac_q[14:0], 1'b1};
				m_q <= 33'(msq >> 1);
			end else begin
				frac_q <= {frac_q[14:0], 1'b0};
				m_q <= 33'(msq);
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign result = {n_q, frac_q};
endmodule

[rtl/bec_divider.sv]
// Restoring divider, one quotient bit per cycle.
module bec_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] q_q;
	logic [W-1:0] r_q;
	logic [W-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;

	assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = q_q;
endmodule

[rtl/bec_ctrl.sv]
// Controller state machine for the entropy pass.
module bec_ctrl import bec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       last_in,
	input  logic       out_taken,
	input  bec_sts_t   sts,
	output bec_state_t state,
	output bec_cmd_t   cmd
);
	bec_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: if (last_in) state_d = ST_SUM_RD;
			ST_SUM_RD: state_d = ST_SUM_LOG;
			ST_SUM_LOG: state_d = ST_SUM_ACC;
			ST_SUM_ACC: begin
				if (!sts.log_busy) begin
					state_d = sts.bin_wrap ? ST_WHOLE : ST_SUM_RD;
				end
			end
			ST_WHOLE: if (!sts.log_busy) state_d = ST_DIV;
			ST_DIV: if (!sts.div_busy) state_d = ST_CLASS;
			ST_CLASS: state_d = ST_CONF;
			ST_CONF: if (!sts.div_busy) state_d = ST_OUT;
			ST_OUT: if (out_taken) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_SUM_LOG: cmd.start_log = 1'b1;
			ST_SUM_ACC: begin
				if (!sts.log_busy) begin
					cmd.acc_part = 1'b1;
					cmd.next_bin = 1'b1;
					if (sts.bin_wrap) cmd.start_log = 1'b1;
				end
			end
			ST_WHOLE: begin
				if (!sts.log_busy) begin
					cmd.load_whole = 1'b1;
					cmd.start_div = 1'b1;
				end
			end
			ST_DIV: if (!sts.div_busy) cmd.finish_h = 1'b1;
			ST_CLASS: cmd.start_conf = 1'b1;
			ST_CONF: if (!sts.div_busy) cmd.finish_conf = 1'b1;
			ST_OUT: if (out_taken) cmd.clear_bins = 1'b1;
			default: ;
		endcase
	end

	assign state = state_q;
endmodule

[rtl/bec_datapath.sv]
// Datapath: histogram RAM, counters, log2 and divider units.
module bec_datapath import bec_pkg::*; #(
	parameter int COUNT_LOG2 = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bec_state_t          state,
	input  bec_cmd_t            cmd,
	output bec_sts_t            sts,
	input  logic                in_take,
	input  logic [7:0]          byte_value,
	input  logic                has_byte,
	input  logic [14:0]         high_thr,
	input  logic [14:0]         med_thr,
	output logic [15:0]         entropy_bits,
	output logic                pack_flag,
	output logic                comp_flag,
	output logic [15:0]         pack_conf,
	output logic [24:0]         total_bytes
);
	localparam int CW = COUNT_LOG2 + 1;
	localparam int LW = $clog2(CW) + 16;
	localparam int PW = CW + LW;
	localparam int DW = PW + 5;

	logic [CW-1:0] total_q;
	logic [BINS-1:0] valid_q;
	logic [BIN_W-1:0] sweep_q;
	logic [BIN_W-1:0] raddr;
	logic [CW-1:0] rdata;
	logic [CW-1:0] bin_val;
	logic we;
	logic [BIN_W-1:0] waddr;
	logic [CW-1:0] wdata;
	logic fwd_s1;
	logic [CW-1:0] fwd_val_s1;
	logic [BIN_W-1:0] wa_s1;
	logic upd_s1;
	logic [CW-1:0] cur_s1;
	logic [CW-1:0] fval_q;
	logic [PW-1:0] parts_q;
	logic [PW-1:0] whole;
	logic [PW-1:0] diff;
	logic log_start;
	logic [CW-1:0] log_x;
	logic log_busy;
	logic [LW-1:0] log_res;
	logic div_start;
	logic [DW-1:0] div_a, div_b, div_q;
	logic div_busy;
	logic [15:0] h_q;
	logic packed_q, comp_q;
	logic [15:0] conf_q;
	logic cnt_ok;

	assign cnt_ok = (total_q[CW-1] == 1'b0);

	// byte path: read in accept cycle, write next cycle
	assign raddr = (state == ST_RUN) ? byte_value : sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			upd_s1 <= in_take && has_byte && cnt_ok;
			fwd_s1 <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= byte_value;
		fwd_val_s1 <= wdata;
	end

	always_comb begin
		bin_val = fwd_s1 ? fwd_val_s1 : rdata;
		cur_s1 = valid_q[wa_s1] ? bin_val : '0;
	end

	assign we = upd_s1;
	assign waddr = wa_s1;
	assign wdata = cur_s1 + 1'b1;

	bec_ram #(.WIDTH(CW), .DEPTH(BINS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			sweep_q <= '0;
		end else if (cmd.clear_bins) begin
			valid_q <= '0;
			total_q <= '0;
			sweep_q <= '0;
		end else begin
			if (we) valid_q[waddr] <= 1'b1;
			if (in_take && has_byte && cnt_ok) total_q <= total_q + 1'b1;
			if (cmd.next_bin) sweep_q <= sweep_q + 1'b1;
		end
	end

	// sweep: register bin value when read returns
	always_ff @(posedge clk) begin
		if (state == ST_SUM_LOG) begin
			fval_q <= valid_q[sweep_q] ? bin_val : '0;
		end
	end

	assign log_start = cmd.start_log;
	assign log_x = (state == ST_SUM_LOG) ? (valid_q[sweep_q] ? bin_val : '0) : total_q;

	bec_log2 #(.XW(CW)) u_log (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(log_x),
		.busy(log_busy), .result(log_res)
	);

	always_ff @(posedge clk) begin
		if (state == ST_RUN) begin
			parts_q <= '0;
		end else if (cmd.acc_part && fval_q != '0) begin
			parts_q <= parts_q + PW'(fval_q * log_res);
		end
	end

	assign whole = PW'(total_q * log_res);
	assign diff = (whole > parts_q) ? whole - parts_q : '0;

	always_comb begin
		if (cmd.start_div) begin
			div_a = DW'(diff) + DW'({total_q, 3'd0});
			div_b = DW'({total_q, 4'd0});
		end else begin
			div_a = DW'({(16'(h_q) - 16'(high_thr)), 16'd0});
			div_b = DW'(ENTROPY_MAX - 16'(high_thr));
		end
	end

	// confidence pass always runs; the quotient is dropped when not packed
	assign div_start = cmd.start_div || cmd.start_conf;

	bec_divider #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .quotient(div_q)
	);

	always_ff @(posedge clk) begin
		if (cmd.finish_h) begin
			if (total_q == '0) h_q <= '0;
			else if (div_q > DW'(ENTROPY_MAX)) h_q <= ENTROPY_MAX;
			else h_q <= div_q[15:0];
		end
		if (state == ST_CLASS) begin
			packed_q <= h_q > 16'(high_thr);
			comp_q <= !(h_q > 16'(high_thr)) && (h_q > 16'(med_thr));
		end
		if (cmd.finish_conf) begin
			if (!packed_q) conf_q <= '0;
			else if (div_q > DW'(16'hFFFF)) conf_q <= 16'hFFFF;
			else conf_q <= div_q[15:0];
		end
	end

	assign sts.log_busy = log_busy;
	assign sts.div_busy = div_busy;
	assign sts.bin_wrap = (sweep_q == '1);
	assign sts.count_zero = (total_q == '0);
	assign sts.packed_flag = packed_q;

	assign entropy_bits = h_q;
	assign pack_flag = packed_q;
	assign comp_flag = comp_q;
	assign pack_conf = conf_q;
	assign total_bytes = 25'(total_q);
endmodule

[rtl/byte_entropy_classifier.sv]
// Top level: byte entropy classifier with stream ports and config writes.
// Sequence: the last transaction starts a 256-bin sweep with a 16-step log2 per bin,
// then a log2 of the count and two divider passes that produce the result.
// Input stays closed until the result transaction.
// Throughput: one byte transaction per cycle while the file streams in.
// Reset: arst_n clears the histogram valid bits, count and FSM, and loads the default thresholds.
module byte_entropy_classifier import bec_pkg::*; #(
	parameter int COUNT_LOG2 = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] byte_value
	input  logic        s_tuser,  // has_byte
	input  logic        s_tlast,  // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [15:0] entropy, [31:16] confidence, [56:32] byte total
	output logic [1:0]  m_tuser,  // [0] packed flag, [1] compressed flag
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);
	bec_state_t state;
	bec_cmd_t cmd;
	bec_sts_t sts;
	logic [14:0] high_q, med_q;
	logic in_take;
	logic [15:0] h, conf;
	logic [24:0] total;
	logic pk, cp;

	// Thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= HIGH_RESET;
			med_q <= MEDIUM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_HIGH) high_q <= cfg_data;
			else med_q <= cfg_data;
		end
	end

	// Bytes stream in while the sweep is idle
	assign s_tready = (state == ST_RUN);
	assign in_take = s_tvalid && s_tready;

	bec_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .last_in(in_take && s_tlast),
		.out_taken(m_tready), .sts(sts), .state(state), .cmd(cmd)
	);

	bec_datapath #(.COUNT_LOG2(COUNT_LOG2)) u_dp (
		.clk(clk), .arst_n(arst_n), .state(state), .cmd(cmd), .sts(sts),
		.in_take(in_take), .byte_value(s_tdata), .has_byte(s_tuser),
		.high_thr(high_q), .med_thr(med_q), .entropy_bits(h),
		.pack_flag(pk), .comp_flag(cp),
		.pack_conf(conf), .total_bytes(total)
	);

	assign m_tvalid = (state == ST_OUT);
	assign m_tdata = {7'd0, total, conf, h};
	assign m_tuser = {cp, pk};

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1])) else $error("both flags set");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input open during result");
	a_conf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[31:16] == 16'd0))
		else $error("confidence without packed");
endmodule
